>>> hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, switched off while reset is held.
`define GLP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent check that also runs through reset.
`define GLP_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hdl/glp_pkg.sv
`timescale 1ns / 1ps

package glp_pkg;

  localparam int DEF_MAX_COLS    = 32;
  localparam int DEF_MAX_ROWS    = 1024;
  localparam int DEF_VALUE_WIDTH = 32;

  // Configuration port
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 11;
  localparam int GRID_ROWS_W = 11;
  localparam int GRID_COLS_W = 6;

  localparam logic [CFG_ADDR_W-1:0] REG_GRID_ROWS = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_GRID_COLS = CFG_ADDR_W'(1);

  // Three rotating line buffers: current, middle and above
  localparam int NUM_BANKS = 3;
  localparam int BANK_W    = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH1,
    ST_FETCH2,
    ST_CMP,
    ST_DECIDE,
    ST_NEXT,
    ST_FINISH
  } glp_state_t;

  typedef struct packed {
    logic accept;       // input item taken this cycle
    logic start_sweep;  // switch to the last-row sweep
    logic rd_next;      // read the right-hand neighbour
    logic cap_win;      // capture left, centre and upper values
    logic cmp;          // evaluate the peak test
    logic k_inc;        // advance the sweep column
    logic pend_load;    // park the decided peak
    logic pend_clr;     // drop the parked peak
    logic out_load;     // load the output register
    logic out_marker;   // output is the end marker
    logic out_done;     // output closes the grid
  } glp_cmd_t;

  typedef struct packed {
    logic first_row;    // incoming item lies on row zero
    logic sweep;        // last-row sweep in progress
    logic final_item;   // item in work closes the grid
    logic k_last;       // column under test is the last one
    logic peak;         // peak test result
    logic pend_valid;   // a peak is parked
    logic out_free;     // output register can take a result
  } glp_status_t;

endpackage

>>> hdl/grid_local_peak_finder.sv
`timescale 1ns / 1ps
// Channel   Handshake             Payload
// in        in_valid / in_ready   in_cell_value (signed, VALUE_WIDTH bits)
// out       out_valid / out_ready out_peak_row, out_peak_col, out_is_peak, out_grid_done
// cfg       cfg_we (no wait)      cfg_index, cfg_wdata (grid_rows, grid_cols)
//
// An item on row zero only fills the line buffer. Every later item steps through two
// line buffer reads, a compare, a decide step and a next step, set by the single read
// pair that each line buffer bank offers. The closing item of a grid then sweeps every
// column of the last row through the same steps and ends with a finish step.
// Reset is synchronous: grid size 2 x 2, position zero; line buffers are not cleared.
// A full output register holds the decide, next and finish steps until it drains.

module grid_local_peak_finder #(
  parameter int VALUE_WIDTH = glp_pkg::DEF_VALUE_WIDTH,
  parameter int MAX_ROWS    = glp_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS    = glp_pkg::DEF_MAX_COLS,
  localparam int RW = $clog2(MAX_ROWS),
  localparam int CW = $clog2(MAX_COLS)
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [VALUE_WIDTH-1:0]         in_cell_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic        [RW-1:0]                  out_peak_row,
  output logic        [CW-1:0]                  out_peak_col,
  output logic                                  out_is_peak,
  output logic                                  out_grid_done,
  input  logic                                  cfg_we,
  input  logic        [glp_pkg::CFG_ADDR_W-1:0] cfg_index,
  input  logic        [glp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  glp_pkg::glp_cmd_t    cmd;
  glp_pkg::glp_status_t status;

  // Sequence each item: accept, fetch the neighbourhood, decide, emit
  glp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Line buffers, position counters, peak test and output register
  glp_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLS    (MAX_COLS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_cell_value (in_cell_value),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_peak_row  (out_peak_row),
    .out_peak_col  (out_peak_col),
    .out_is_peak   (out_is_peak),
    .out_grid_done (out_grid_done),
    .cmd           (cmd),
    .status        (status)
  );

endmodule

>>> hdl/glp_ctrl.sv
`timescale 1ns / 1ps

module glp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  glp_pkg::glp_status_t status,
  output glp_pkg::glp_cmd_t    cmd
);

  glp_pkg::glp_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= glp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      glp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          // row zero items only fill the line buffer
          if (!status.first_row) begin
            state_nxt = glp_pkg::ST_FETCH1;
          end
        end
      end
      glp_pkg::ST_FETCH1: begin
        state_nxt = glp_pkg::ST_FETCH2;
      end
      glp_pkg::ST_FETCH2: begin
        cmd.rd_next = 1'b1;
        cmd.cap_win = 1'b1;
        state_nxt   = glp_pkg::ST_CMP;
      end
      glp_pkg::ST_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = glp_pkg::ST_DECIDE;
      end
      glp_pkg::ST_DECIDE: begin
        priority if (!status.peak) begin
          state_nxt = glp_pkg::ST_NEXT;
        end else if (!status.pend_valid) begin
          cmd.pend_load = 1'b1;
          state_nxt     = glp_pkg::ST_NEXT;
        end else if (status.out_free) begin
          // push the older peak out, park the new one
          cmd.out_load  = 1'b1;
          cmd.pend_load = 1'b1;
          state_nxt     = glp_pkg::ST_NEXT;
        end else begin
          // hold until the output register drains
          state_nxt = glp_pkg::ST_DECIDE;
        end
      end
      glp_pkg::ST_NEXT: begin
        priority if (status.sweep) begin
          if (status.k_last) begin
            state_nxt = glp_pkg::ST_FINISH;
          end else begin
            cmd.k_inc = 1'b1;
            state_nxt = glp_pkg::ST_FETCH1;
          end
        end else if (status.final_item) begin
          cmd.start_sweep = 1'b1;
          state_nxt       = glp_pkg::ST_FETCH1;
        end else if (!status.pend_valid) begin
          state_nxt = glp_pkg::ST_IDLE;
        end else if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.pend_clr = 1'b1;
          state_nxt    = glp_pkg::ST_IDLE;
        end else begin
          // hold until the output register drains
          state_nxt = glp_pkg::ST_NEXT;
        end
      end
      glp_pkg::ST_FINISH: begin
        if (status.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_marker = !status.pend_valid;
          cmd.out_done   = 1'b1;
          cmd.pend_clr   = 1'b1;
          state_nxt      = glp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = glp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/glp_datapath.sv
`timescale 1ns / 1ps

module glp_datapath #(
  parameter int VALUE_WIDTH = glp_pkg::DEF_VALUE_WIDTH,
  parameter int MAX_ROWS    = glp_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS    = glp_pkg::DEF_MAX_COLS,
  localparam int RW = $clog2(MAX_ROWS),
  localparam int CW = $clog2(MAX_COLS)
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic signed [VALUE_WIDTH-1:0]        in_cell_value,
  input  logic                                 cfg_we,
  input  logic        [glp_pkg::CFG_ADDR_W-1:0] cfg_index,
  input  logic        [glp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic        [RW-1:0]                 out_peak_row,
  output logic        [CW-1:0]                 out_peak_col,
  output logic                                 out_is_peak,
  output logic                                 out_grid_done,
  input  glp_pkg::glp_cmd_t                    cmd,
  output glp_pkg::glp_status_t                 status
);

  localparam int BW = glp_pkg::BANK_W;

  // Bank that lies n rows back from b, modulo the bank count
  function automatic logic [BW-1:0] bank_back(input logic [BW-1:0] b, input logic [BW-1:0] n);
    logic [BW:0] s;
    s = {1'b0, b} + BW'(glp_pkg::NUM_BANKS) - {1'b0, n};
    if (s >= (BW+1)'(glp_pkg::NUM_BANKS)) begin
      s = s - (BW+1)'(glp_pkg::NUM_BANKS);
    end
    return s[BW-1:0];
  endfunction

  logic [glp_pkg::GRID_ROWS_W-1:0] grid_rows_r;
  logic [glp_pkg::GRID_COLS_W-1:0] grid_cols_r;
  logic [RW-1:0] rows_last;
  logic [CW-1:0] cols_last;

  logic [RW-1:0] row_pos_r;
  logic [CW-1:0] col_pos_r;
  logic [BW-1:0] cur_bank_r;
  logic          row_end, grid_end, cfg_hit;

  logic signed [VALUE_WIDTH-1:0] bank_mem [glp_pkg::NUM_BANKS][MAX_COLS];
  logic signed [VALUE_WIDTH-1:0] rd_a_r [glp_pkg::NUM_BANKS];
  logic signed [VALUE_WIDTH-1:0] rd_b_r [glp_pkg::NUM_BANKS];
  logic        [CW-1:0]          addr_a, addr_b;

  logic signed [VALUE_WIDTH-1:0] value_r, win_l_r, win_c_r, win_u_r;
  logic signed [VALUE_WIDTH-1:0] x_a, x_b, y_a;
  logic [CW-1:0] k_r;
  logic [RW-1:0] dec_row_r;
  logic [BW-1:0] xsel_r, ysel_r;
  logic          has_up_r, sweep_r, final_r, peak_r;
  logic          pend_v_r;
  logic [RW-1:0] pend_row_r;
  logic [CW-1:0] pend_col_r;
  logic          out_valid_r;
  logic          peak_test;

  // Clamp the grid size to what the line buffers and counters hold
  always_comb begin
    if (32'(grid_rows_r) < 32'd2) begin
      rows_last = RW'(1);
    end else if (32'(grid_rows_r) > MAX_ROWS) begin
      rows_last = RW'(MAX_ROWS - 1);
    end else begin
      rows_last = RW'(32'(grid_rows_r) - 32'd1);
    end
    if (32'(grid_cols_r) < 32'd2) begin
      cols_last = CW'(1);
    end else if (32'(grid_cols_r) > MAX_COLS) begin
      cols_last = CW'(MAX_COLS - 1);
    end else begin
      cols_last = CW'(32'(grid_cols_r) - 32'd1);
    end
  end

  assign row_end  = (col_pos_r == cols_last);
  assign grid_end = row_end && (row_pos_r == rows_last);
  assign cfg_hit  = cfg_we && ((cfg_index == glp_pkg::REG_GRID_ROWS) ||
                               (cfg_index == glp_pkg::REG_GRID_COLS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= glp_pkg::GRID_ROWS_W'(2);
      grid_cols_r <= glp_pkg::GRID_COLS_W'(2);
      row_pos_r   <= '0;
      col_pos_r   <= '0;
      cur_bank_r  <= '0;
    end else if (cfg_hit) begin
      if (cfg_index == glp_pkg::REG_GRID_ROWS) begin
        grid_rows_r <= cfg_wdata[glp_pkg::GRID_ROWS_W-1:0];
      end else begin
        grid_cols_r <= cfg_wdata[glp_pkg::GRID_COLS_W-1:0];
      end
      row_pos_r <= '0;
      col_pos_r <= '0;
    end else if (cmd.accept) begin
      priority if (grid_end) begin
        row_pos_r <= '0;
        col_pos_r <= '0;
      end else if (row_end) begin
        row_pos_r  <= row_pos_r + RW'(1);
        col_pos_r  <= '0;
        cur_bank_r <= bank_back(cur_bank_r, BW'(glp_pkg::NUM_BANKS - 1));
      end else begin
        col_pos_r <= col_pos_r + CW'(1);
      end
    end
  end

  // Line buffers: one write port, two read ports shared by address
  assign addr_a = cmd.rd_next ? (k_r + CW'(1)) : k_r;
  assign addr_b = k_r - CW'(1);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      bank_mem[cur_bank_r][col_pos_r] <= in_cell_value;
    end
    for (int b = 0; b < glp_pkg::NUM_BANKS; b++) begin
      rd_a_r[b] <= bank_mem[b][addr_a];
      rd_b_r[b] <= bank_mem[b][addr_b];
    end
  end

  assign x_a = rd_a_r[xsel_r];
  assign x_b = rd_b_r[xsel_r];
  assign y_a = rd_a_r[ysel_r];

  // Edges drop the neighbours outside the grid
  assign peak_test = !((k_r != '0) && (win_c_r < win_l_r)) &&
                     !((k_r != cols_last) && (win_c_r < x_a)) &&
                     !(has_up_r && (win_c_r < win_u_r)) &&
                     !(!sweep_r && (win_c_r < value_r));

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      value_r   <= in_cell_value;
      k_r       <= col_pos_r;
      dec_row_r <= row_pos_r - RW'(1);
      xsel_r    <= bank_back(cur_bank_r, BW'(1));
      ysel_r    <= bank_back(cur_bank_r, BW'(2));
      has_up_r  <= (row_pos_r > RW'(1));
      sweep_r   <= 1'b0;
      final_r   <= grid_end;
    end else if (cmd.start_sweep) begin
      k_r       <= '0;
      dec_row_r <= dec_row_r + RW'(1);
      xsel_r    <= cur_bank_r;
      ysel_r    <= bank_back(cur_bank_r, BW'(1));
      has_up_r  <= 1'b1;
      sweep_r   <= 1'b1;
    end else if (cmd.k_inc) begin
      k_r <= k_r + CW'(1);
    end
    if (cmd.cap_win) begin
      win_c_r <= x_a;
      win_l_r <= x_b;
      win_u_r <= y_a;
    end
    if (cmd.cmp) begin
      peak_r <= peak_test;
    end
    if (cmd.pend_load) begin
      pend_row_r <= dec_row_r;
      pend_col_r <= k_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else if (cmd.pend_load) begin
      pend_v_r <= 1'b1;
    end else if (cmd.pend_clr) begin
      pend_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_peak_row  <= cmd.out_marker ? '0 : pend_row_r;
      out_peak_col  <= cmd.out_marker ? '0 : pend_col_r;
      out_is_peak   <= !cmd.out_marker;
      out_grid_done <= cmd.out_done;
    end
  end

  assign out_valid = out_valid_r;

  assign status.first_row  = (row_pos_r == '0);
  assign status.sweep      = sweep_r;
  assign status.final_item = final_r;
  assign status.k_last     = (k_r == cols_last);
  assign status.peak       = peak_r;
  assign status.pend_valid = pend_v_r;
  assign status.out_free   = !out_valid_r || out_ready;

endmodule

>>> hdl/glp_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module glp_checker #(
  parameter int MAX_ROWS = glp_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = glp_pkg::DEF_MAX_COLS,
  localparam int RW = $clog2(MAX_ROWS),
  localparam int CW = $clog2(MAX_COLS)
) (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_ready,
  input logic [RW-1:0] out_peak_row,
  input logic [CW-1:0] out_peak_col,
  input logic          out_is_peak,
  input logic          out_grid_done
);

  // A stalled result holds its payload
  `GLP_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_peak_row) && $stable(out_peak_col) && $stable(out_is_peak) && $stable(out_grid_done), "stalled result changed")

  // Nothing is offered straight after reset
  `GLP_ASSERT_NORST(a_reset_empty, clk, !rst_n |=> !out_valid, "result offered after reset")

  // The end marker always closes the grid
  `GLP_ASSERT(a_marker_done, clk, rst_n, out_valid && !out_is_peak |-> out_grid_done, "end marker without grid done")

  // The end marker carries zero coordinates
  `GLP_ASSERT(a_marker_zero, clk, rst_n, out_valid && !out_is_peak |-> out_peak_row == '0 && out_peak_col == '0, "end marker with coordinates")

endmodule

bind grid_local_peak_finder glp_checker #(
  .MAX_ROWS (MAX_ROWS),
  .MAX_COLS (MAX_COLS)
) u_glp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_peak_row  (out_peak_row),
  .out_peak_col  (out_peak_col),
  .out_is_peak   (out_is_peak),
  .out_grid_done (out_grid_done)
);
